// ----- rtl/cfd_pkg.sv -----
`default_nettype none
package cfd_pkg;

  localparam int MAX_FRAME_DEFAULT = 15;

  // Bytes of a frame that any kind ever uses (the longest kind is fifteen bytes).
  localparam int USED_BYTES = 15;

  localparam logic [63:0] OPCODE_TABLE_RESET = 64'h0706_0504_0302_0100;
  localparam logic [7:0]  WRITE_OPCODE_RESET = 8'd8;

  localparam logic [1:0] REG_OPCODE_TABLE = 2'd0;
  localparam logic [1:0] REG_WRITE_OPCODE = 2'd1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_CHECK     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN   = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;

  localparam logic [3:0] KIND_SYNC  = 4'd0;
  localparam logic [3:0] KIND_BUMP  = 4'd1;
  localparam logic [3:0] KIND_NEW   = 4'd2;
  localparam logic [3:0] KIND_CLEAR = 4'd3;
  localparam logic [3:0] KIND_ADD   = 4'd4;
  localparam logic [3:0] KIND_RUN   = 4'd5;
  localparam logic [3:0] KIND_STOP  = 4'd6;
  localparam logic [3:0] KIND_MOVE  = 4'd7;
  localparam logic [3:0] KIND_WRITE = 4'd8;

  // A classified frame: status, kind and the body bytes after the type byte.
  typedef struct packed {
    logic [2:0]       status;
    logic [3:0]       kind;
    logic [14:1][7:0] body;
  } cfd_rec_t;

  function automatic logic [7:0] kind_length(input logic [3:0] kind);
    logic [7:0] len;
    unique case (kind)
      KIND_SYNC:  len = 8'd2;
      KIND_BUMP:  len = 8'd6;
      KIND_NEW:   len = 8'd4;
      KIND_CLEAR: len = 8'd3;
      KIND_ADD:   len = 8'd15;
      KIND_RUN:   len = 8'd7;
      KIND_STOP:  len = 8'd2;
      KIND_MOVE:  len = 8'd11;
      KIND_WRITE: len = 8'd10;
      default:    len = 8'd0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cfd_front.sv -----
`default_nettype none
module cfd_front #(
  parameter int MAX_FRAME = cfd_pkg::MAX_FRAME_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [7:0]       data_byte,
  input  wire logic             last_byte,
  input  wire logic             cfg_write,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [63:0]      cfg_data,
  output cfd_pkg::cfd_rec_t     rec,
  output logic                  rec_push
);
  import cfd_pkg::*;

  localparam int IDX_W = $clog2(MAX_FRAME);
  localparam logic [7:0] MAX_CNT = 8'(MAX_FRAME);

  logic [63:0] opcode_table;
  logic [7:0]  write_opcode;
  logic [7:0]  byte_count;
  logic [7:0]  running_xor;
  logic [7:0]  frame_store [MAX_FRAME];

  logic [7:0]  xor_next;
  logic [7:0]  len;
  logic [USED_BYTES-1:0][7:0] view;
  logic        found;
  logic [3:0]  kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      opcode_table <= OPCODE_TABLE_RESET;
      write_opcode <= WRITE_OPCODE_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_OPCODE_TABLE) begin
        opcode_table <= cfg_data;
      end else if (cfg_index == REG_WRITE_OPCODE) begin
        write_opcode <= cfg_data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_xor <= '0;
    end else if (accept) begin
      if (last_byte) begin
        byte_count  <= '0;
        running_xor <= '0;
      end else begin
        byte_count  <= len;
        running_xor <= xor_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_count < MAX_CNT) begin
      frame_store[byte_count[IDX_W-1:0]] <= data_byte;
    end
  end

  assign xor_next = running_xor ^ data_byte;
  assign len      = (byte_count == 8'hFF) ? 8'hFF : byte_count + 8'd1;

  // The byte arriving now is seen in place, so the last byte counts too.
  always_comb begin
    for (int j = 0; j < USED_BYTES; j++) begin
      view[j] = (byte_count == 8'(j)) ? data_byte : frame_store[j];
    end
  end

  // Scanning from the top down leaves the lowest matching kind in place.
  always_comb begin
    found = 1'b0;
    kind  = KIND_SYNC;
    for (int k = 7; k >= 0; k--) begin
      if (opcode_table[8*k +: 8] == view[0]) begin
        found = 1'b1;
        kind  = 4'(k);
      end
    end
    if (!found && view[0] == write_opcode) begin
      found = 1'b1;
      kind  = KIND_WRITE;
    end
  end

  always_comb begin
    rec.kind = kind;
    for (int j = 1; j < USED_BYTES; j++) begin
      rec.body[j] = view[j];
    end
    priority if (len < 8'd2) begin
      rec.status = ST_SHORT;
    end else if (xor_next != 8'd0) begin
      rec.status = ST_CHECK;
    end else if (!found) begin
      rec.status = ST_UNKNOWN;
    end else if (len != kind_length(kind)) begin
      rec.status = ST_BAD_LEN;
    end else begin
      rec.status = ST_OK;
    end
  end

  assign rec_push = accept && last_byte;

endmodule
`default_nettype wire

// ----- rtl/cfd_queue.sv -----
`default_nettype none
module cfd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  cfd_pkg::cfd_rec_t  push_rec,
  output logic               full,
  input  wire logic          take,
  output cfd_pkg::cfd_rec_t  head,
  output logic               avail
);
  import cfd_pkg::*;

  cfd_rec_t    entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        do_push;
  logic        do_take;

  assign full    = (fill == 2'd2);
  assign avail   = (fill != 2'd0);
  assign do_push = push && !full;
  assign do_take = take && avail;
  assign head    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_take) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_push, do_take})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= push_rec;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cfd_back.sv -----
`default_nettype none
module cfd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  cfd_pkg::cfd_rec_t  head,
  input  wire logic          avail,
  output logic               take,
  output logic               empty,
  input  wire logic          pop,
  output logic [2:0]         status,
  output logic [3:0]         command_kind,
  output logic [7:0]         track_number,
  output logic [7:0]         track_kind,
  output logic [31:0]        x_bits,
  output logic [31:0]        y_bits,
  output logic [31:0]        time_value
);
  import cfd_pkg::*;

  logic        out_valid;
  logic [3:0]  kind_d;
  logic [7:0]  tnum_d;
  logic [7:0]  tkind_d;
  logic [31:0] x_d;
  logic [31:0] y_d;
  logic [31:0] t_d;

  assign empty = !out_valid;
  assign take  = avail && (!out_valid || pop);

  always_comb begin
    kind_d  = '0;
    tnum_d  = '0;
    tkind_d = '0;
    x_d     = '0;
    y_d     = '0;
    t_d     = '0;
    if (head.status == ST_OK) begin
      kind_d = head.kind;
      unique case (head.kind)
        KIND_BUMP: begin
          t_d = {head.body[4], head.body[3], head.body[2], head.body[1]};
        end
        KIND_NEW: begin
          tnum_d  = head.body[1];
          tkind_d = head.body[2];
        end
        KIND_CLEAR: begin
          tnum_d = head.body[1];
        end
        KIND_ADD: begin
          tnum_d = head.body[1];
          x_d = {head.body[5], head.body[4], head.body[3], head.body[2]};
          y_d = {head.body[9], head.body[8], head.body[7], head.body[6]};
          t_d = {head.body[13], head.body[12], head.body[11], head.body[10]};
        end
        KIND_RUN: begin
          tnum_d = head.body[1];
          t_d = {head.body[5], head.body[4], head.body[3], head.body[2]};
        end
        KIND_MOVE: begin
          tnum_d = head.body[1];
          x_d = {head.body[5], head.body[4], head.body[3], head.body[2]};
          y_d = {head.body[9], head.body[8], head.body[7], head.body[6]};
        end
        KIND_WRITE: begin
          x_d = {head.body[4], head.body[3], head.body[2], head.body[1]};
          y_d = {head.body[8], head.body[7], head.body[6], head.body[5]};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status       <= head.status;
      command_kind <= kind_d;
      track_number <= tnum_d;
      track_kind   <= tkind_d;
      x_bits       <= x_d;
      y_bits       <= y_d;
      time_value   <= t_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/command_frame_deframer.sv -----
// Command frame deframer.
// Input channel: one frame byte per item on data_byte, with last_byte high on
// the final (check) byte; an item is taken on a clock edge with push high and
// full low. A byte can be taken in every cycle while full is low.
// Result channel: one result per frame, given after its final byte. The oldest
// result sits on the result ports while empty is low and leaves on an edge
// with pop high. The edge that takes the final byte queues the classified
// frame, and a later edge, once the output register is empty or being popped,
// decodes its fields into the output register.
// A two-entry queue between the classifier and the output register lets the
// input side keep going while a result waits; full rises only once two
// classified frames are queued behind an output that is not being popped.
// Sustained throughput is one byte per cycle while full stays low.
// Configuration: cfg_write with cfg_index 0 loads the opcode table, index 1
// the write opcode; other indexes are ignored. Write only while idle.
// Reset (rst, synchronous) clears the byte count, check sum, queue and output
// valid flag, and restores the default opcodes.
`default_nettype none
module command_frame_deframer #(
  parameter int MAX_FRAME = cfd_pkg::MAX_FRAME_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       status,
  output logic [3:0]       command_kind,
  output logic [7:0]       track_number,
  output logic [7:0]       track_kind,
  output logic [31:0]      x_bits,
  output logic [31:0]      y_bits,
  output logic [31:0]      time_value,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import cfd_pkg::*;

  cfd_rec_t rec;
  cfd_rec_t head;
  logic     rec_push;
  logic     avail;
  logic     take;
  logic     accept;

  assign accept = push && !full;

  cfd_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rec       (rec),
    .rec_push  (rec_push)
  );

  cfd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_push),
    .push_rec (rec),
    .full     (full),
    .take     (take),
    .head     (head),
    .avail    (avail)
  );

  cfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .avail        (avail),
    .take         (take),
    .empty        (empty),
    .pop          (pop),
    .status       (status),
    .command_kind (command_kind),
    .track_number (track_number),
    .track_kind   (track_kind),
    .x_bits       (x_bits),
    .y_bits       (y_bits),
    .time_value   (time_value)
  );

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import cfd_pkg::*;

  localparam int          FRAME_CAP   = MAX_FRAME_DEFAULT;
  localparam int          CAP_W       = $clog2(FRAME_CAP);
  localparam int unsigned PHASE_BYTES = 236;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned NUM_PHASES  = 7;

  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;

  // Fixed frame length of each kind, kind 0 in the lowest element.
  localparam logic [8:0][7:0] FRAME_LEN = {8'd10, 8'd11, 8'd2, 8'd7, 8'd15,
                                           8'd3, 8'd4, 8'd6, 8'd2};

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  command_kind;
    logic [7:0]  track_number;
    logic [7:0]  track_kind;
    logic [31:0] x_bits;
    logic [31:0] y_bits;
    logic [31:0] time_value;
  } deframe_result_t;

  typedef struct {
    logic [7:0]      data;
    logic            fin;
    bit              typed;
    deframe_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  status;
  logic [3:0]  command_kind;
  logic [7:0]  track_number;
  logic [7:0]  track_kind;
  logic [31:0] x_bits;
  logic [31:0] y_bits;
  logic [31:0] time_value;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [63:0] cfg_data = 64'd0;

  // Expectation pinned to the item currently offered (directed rows only).
  bit              typed_now = 1'b0;
  deframe_result_t want_now = '0;

  // Predictor state and its copy of the registers.
  logic [63:0] opcode_map = OPCODE_TABLE_RESET;
  logic [7:0]  write_op = WRITE_OPCODE_RESET;
  logic [7:0]  frame_len = 8'd0;
  logic [7:0]  frame_xor = 8'd0;
  logic [7:0]  frame_bytes [0:FRAME_CAP-1];

  deframe_result_t frames_due [$];
  stim_row_t       directed_rows [$];

  int unsigned mismatches = 0;
  int unsigned bytes_in = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_checked = 0;
  int unsigned send_calm = 0;
  int unsigned quiet = 0;
  int unsigned status_seen [0:7];

  command_frame_deframer uut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .data_byte(data_byte), .last_byte(last_byte),
    .empty(empty), .pop(pop),
    .status(status), .command_kind(command_kind), .track_number(track_number),
    .track_kind(track_kind), .x_bits(x_bits), .y_bits(y_bits),
    .time_value(time_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] le_word(input int unsigned pos);
    return {frame_bytes[pos+3], frame_bytes[pos+2], frame_bytes[pos+1], frame_bytes[pos]};
  endfunction

  // Takes one accepted byte; on the final byte it decodes the whole frame.
  task automatic predict_byte(input logic [7:0] b, input logic fin,
                              output bit got, output deframe_result_t r);
    logic [3:0]  k;
    bit          hit;
    int unsigned i;
    got = 1'b0;
    r = '0;
    if (frame_len < FRAME_CAP) frame_bytes[frame_len[CAP_W-1:0]] = b;
    frame_xor ^= b;
    if (frame_len != 8'hFF) frame_len++;
    if (fin) begin
      hit = 1'b0;
      k = KIND_SYNC;
      for (i = 0; i < 8; i++) begin
        if (!hit && opcode_map[8*i +: 8] == frame_bytes[0]) begin
          hit = 1'b1;
          k = 4'(i);
        end
      end
      if (!hit && write_op == frame_bytes[0]) begin
        hit = 1'b1;
        k = KIND_WRITE;
      end
      got = 1'b1;
      if (frame_len < 8'd2) r.status = ST_SHORT;
      else if (frame_xor != 8'd0) r.status = ST_CHECK;
      else if (!hit) r.status = ST_UNKNOWN;
      else if (frame_len != FRAME_LEN[k]) r.status = ST_BAD_LEN;
      else begin
        r.status = ST_OK;
        r.command_kind = k;
        case (k)
          KIND_BUMP: r.time_value = le_word(1);
          KIND_NEW: begin
            r.track_number = frame_bytes[1];
            r.track_kind = frame_bytes[2];
          end
          KIND_CLEAR: r.track_number = frame_bytes[1];
          KIND_ADD: begin
            r.track_number = frame_bytes[1];
            r.x_bits = le_word(2);
            r.y_bits = le_word(6);
            r.time_value = le_word(10);
          end
          KIND_RUN: begin
            r.track_number = frame_bytes[1];
            r.time_value = le_word(2);
          end
          KIND_MOVE: begin
            r.track_number = frame_bytes[1];
            r.x_bits = le_word(2);
            r.y_bits = le_word(6);
          end
          KIND_WRITE: begin
            r.x_bits = le_word(1);
            r.y_bits = le_word(5);
          end
          default: ;
        endcase
      end
      frame_len = 8'd0;
      frame_xor = 8'd0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    bit              got;
    bit              moved;
    deframe_result_t r;
    deframe_result_t want;
    moved = 1'b0;
    if (!rst && push && !full) begin
      moved = 1'b1;
      bytes_in++;
      predict_byte(data_byte, last_byte, got, r);
      if (got) frames_due.push_back(typed_now ? want_now : r);
    end
    if (!rst && pop && !empty) begin
      moved = 1'b1;
      if (frames_due.size() == 0) begin
        $error("result with no frame waiting: status %0d kind %0d", status, command_kind);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("command_kind", 32'(want.command_kind), 32'(command_kind));
        check_field("track_number", 32'(want.track_number), 32'(track_number));
        check_field("track_kind", 32'(want.track_kind), 32'(track_kind));
        check_field("x_bits", want.x_bits, x_bits);
        check_field("y_bits", want.y_bits, y_bits);
        check_field("time_value", want.time_value, time_value);
        status_seen[want.status]++;
        frames_checked++;
      end
    end
    if (moved || rst) quiet = 0;
    else quiet++;
    if (quiet == QUIET_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Result side: random stalls with calm stretches in between.
  initial begin : result_side
    int unsigned hold;
    int unsigned calm;
    hold = 0;
    calm = 0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop <= 1'b1;
        if (calm != 0) calm--;
        else if ($urandom_range(0, 5) == 0) hold = idle_len();
        else if ($urandom_range(0, 39) == 0) calm = $urandom_range(20, 100);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
                           input deframe_result_t want);
    int unsigned gap;
    gap = 0;
    if (send_calm != 0) send_calm--;
    else if ($urandom_range(0, 4) == 0) gap = idle_len();
    else if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 80);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    last_byte <= fin;
    typed_now <= typed;
    want_now <= want;
    @(posedge clk);
    while (full) @(posedge clk);
    bytes_sent++;
  endtask

  // Builds one frame aimed at the current opcodes. A non-zero stretch forces
  // a well-checked frame of that many bytes.
  task automatic send_random_frame(input int unsigned stretch);
    logic [7:0]  bytes [$];
    logic [7:0]  acc;
    int unsigned pick;
    int unsigned k;
    int unsigned n;
    int unsigned j;
    bit          good_check;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, 8);
    n = 32'(FRAME_LEN[k]);
    good_check = 1'b1;
    bytes.push_back(k == 8 ? write_op : opcode_map[8*k +: 8]);
    if (stretch != 0) n = stretch;
    else if (pick < 68) ;
    else if (pick < 74) begin
      // A move frame cut to the length of a write frame.
      bytes[0] = opcode_map[8*KIND_MOVE +: 8];
      n = 32'(FRAME_LEN[KIND_WRITE]);
    end else if (pick < 82) n = $urandom_range(2, 17);
    else if (pick < 88) good_check = 1'b0;
    else if (pick < 94) begin
      bytes[0] = 8'($urandom_range(0, 255));
      n = $urandom_range(1, 17);
      good_check = 1'($urandom_range(0, 1));
    end else if (pick < 97) n = 1;
    else n = $urandom_range(16, 40);
    acc = bytes[0];
    for (j = 1; j + 1 < n; j++) begin
      bytes.push_back(8'($urandom_range(0, 255)));
      acc ^= bytes[j];
    end
    if (n > 1) bytes.push_back(good_check ? acc : acc ^ 8'($urandom_range(1, 255)));
    for (j = 0; j < bytes.size(); j++) send_byte(bytes[j], j == bytes.size() - 1, 1'b0, '0);
  endtask

  task automatic random_frames(input int unsigned quota);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < quota) send_random_frame(0);
    push <= 1'b0;
  endtask

  // Waits until every frame has been popped and the pipeline has gone quiet.
  task automatic settle();
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Leaves cfg_write high; the caller lowers it after its last write.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_OPCODE_TABLE: opcode_map = val;
      REG_WRITE_OPCODE: write_op = val[7:0];
      default: ;
    endcase
  endtask

  function automatic deframe_result_t verdict(input logic [2:0] st, input logic [3:0] k,
                                              input logic [31:0] x, input logic [31:0] y);
    deframe_result_t r;
    r = '0;
    r.status = st;
    r.command_kind = k;
    r.x_bits = x;
    r.y_bits = y;
    return r;
  endfunction

  task automatic row(input logic [7:0] b, input logic fin, input bit typed,
                     input deframe_result_t want);
    stim_row_t s;
    s.data = b;
    s.fin = fin;
    s.typed = typed;
    s.want = want;
    directed_rows.push_back(s);
  endtask

  initial begin : stimulus
    int unsigned     i;
    int unsigned     a;
    int unsigned     c;
    logic [63:0]     tbl;
    deframe_result_t none;
    none = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Lone byte: too short.
    row(8'h00, 1'b1, 1'b1, verdict(ST_SHORT, KIND_SYNC, 0, 0));
    // Sync and stop frames with their check bytes.
    row(8'h00, 1'b0, 1'b0, none);
    row(8'h00, 1'b1, 1'b1, verdict(ST_OK, KIND_SYNC, 0, 0));
    row(8'h06, 1'b0, 1'b0, none);
    row(8'h06, 1'b1, 1'b1, verdict(ST_OK, KIND_STOP, 0, 0));
    // Bad check byte.
    row(8'h05, 1'b0, 1'b0, none);
    row(8'h04, 1'b1, 1'b1, verdict(ST_CHECK, KIND_SYNC, 0, 0));
    // Good check, type not in the table.
    row(8'hFF, 1'b0, 1'b0, none);
    row(8'hFF, 1'b1, 1'b1, verdict(ST_UNKNOWN, KIND_SYNC, 0, 0));
    // Bump frame two bytes long.
    row(8'h01, 1'b0, 1'b0, none);
    row(8'h01, 1'b1, 1'b1, verdict(ST_BAD_LEN, KIND_SYNC, 0, 0));
    // New track with extreme id and type.
    row(8'h02, 1'b0, 1'b0, none);
    row(8'hFF, 1'b0, 1'b0, none);
    row(8'h80, 1'b0, 1'b0, none);
    row(8'h7D, 1'b1, 1'b0, none);
    // Write point with x all ones and only the top bit of y set.
    row(8'h08, 1'b0, 1'b0, none);
    row(8'hFF, 1'b0, 1'b0, none);
    row(8'hFF, 1'b0, 1'b0, none);
    row(8'hFF, 1'b0, 1'b0, none);
    row(8'hFF, 1'b0, 1'b0, none);
    row(8'h00, 1'b0, 1'b0, none);
    row(8'h00, 1'b0, 1'b0, none);
    row(8'h00, 1'b0, 1'b0, none);
    row(8'h80, 1'b0, 1'b0, none);
    row(8'h88, 1'b1, 1'b1, verdict(ST_OK, KIND_WRITE, 32'hFFFF_FFFF, 32'h8000_0000));

    for (i = 0; i < directed_rows.size(); i++)
      send_byte(directed_rows[i].data, directed_rows[i].fin, directed_rows[i].typed,
                directed_rows[i].want);
    random_frames(PHASE_BYTES);

    for (i = 1; i < NUM_PHASES; i++) begin
      settle();
      case (i)
        1: begin
          // Every kind in the table shares one opcode, so the lowest kind always wins.
          write_reg(REG_OPCODE_TABLE, '1);
          write_reg(REG_WRITE_OPCODE, 64'h00);
          write_reg(REG_SPARE_LO, {$urandom, $urandom});
        end
        2: begin
          write_reg(REG_OPCODE_TABLE, 64'd0);
          write_reg(REG_WRITE_OPCODE, 64'hFF);
          write_reg(REG_SPARE_HI, {$urandom, $urandom});
        end
        3: begin
          tbl = {$urandom, $urandom};
          a = $urandom_range(0, 7);
          c = $urandom_range(0, 7);
          tbl[8*a +: 8] = tbl[8*c +: 8];
          write_reg(REG_OPCODE_TABLE, tbl);
          write_reg(REG_WRITE_OPCODE, {56'd0, tbl[8*$urandom_range(0, 7) +: 8]});
        end
        NUM_PHASES - 1: begin
          write_reg(REG_OPCODE_TABLE, OPCODE_TABLE_RESET);
          write_reg(REG_WRITE_OPCODE, {56'd0, WRITE_OPCODE_RESET});
        end
        default: begin
          write_reg(REG_OPCODE_TABLE, {$urandom, $urandom});
          write_reg(REG_WRITE_OPCODE, {56'd0, 8'($urandom_range(0, 255))});
        end
      endcase
      cfg_write <= 1'b0;
      // One frame long enough to saturate the byte count.
      if (i == 1) send_random_frame(270);
      random_frames(PHASE_BYTES);
    end
    settle();

    $display("tb: %0d bytes fed, %0d frames compared over %0d opcode settings",
             bytes_in, frames_checked, NUM_PHASES);
    $display("tb: by status ok %0d, short %0d, check %0d, unknown %0d, length %0d",
             status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_CHECK],
             status_seen[ST_UNKNOWN], status_seen[ST_BAD_LEN]);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
